[rtl/ecmp_pkg.sv]
// ----------------------------------------------------------------------------
// ecmp_pkg: shared types and constants of the tilt-compensated compass
// Controller states, solve steps, the command word and the fixed-point
// constants of the atan polynomial and the angle ranges.
// ----------------------------------------------------------------------------
package ecmp_pkg;

  localparam logic signed [15:0] ATAN_K1    = 16'sd5701;
  localparam logic signed [15:0] ATAN_K2    = -16'sd1645;
  localparam logic signed [15:0] ATAN_K3    = 16'sd446;
  localparam logic signed [15:0] DEG90      = 16'sd9000;
  localparam logic signed [15:0] DEG180     = 16'sd18000;
  localparam logic signed [17:0] DEG360     = 18'sd36000;
  localparam logic signed [15:0] MOST_NEG   = 16'sh8000;
  localparam logic signed [15:0] NEAR_NEG   = 16'sh8001;
  localparam logic [14:0]        GAIN_RESET = 15'd3276;
  // Index of the leading quotient bit (the half step of Q15).
  localparam logic [3:0]         TOP_BIT    = 4'd14;

  typedef enum logic [1:0] {
    REG_HARD_IRON_X = 2'd0,
    REG_HARD_IRON_Y = 2'd1,
    REG_HARD_IRON_Z = 2'd2,
    REG_FILTER_GAIN = 2'd3
  } ecmp_reg_t;

  typedef enum logic [5:0] {
    S_IDLE, S_TPREP, S_TSQX, S_TSQY, S_THYP, S_TB1, S_TB2, S_TB3, S_TEND,
    S_APREP, S_DB1, S_DB2, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_AFIN1, S_AFIN2, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7,
    S_X1, S_X2, S_X3, S_L1, S_L2, S_L3, S_PUSH
  } ecmp_state_t;

  typedef enum logic [3:0] {
    M_ROLL, M_S1, M_C1, M_ROT, M_PITCH, M_S2, M_C2, M_FX, M_YAW,
    M_LPR, M_LPP, M_LPY
  } ecmp_step_t;

  typedef struct packed {
    ecmp_state_t op;
    ecmp_step_t  step;
    logic [3:0]  bitn;
    logic        load;
    logic        push;
  } ecmp_cmd_t;

  // Left shift that brings the leading one of m to bit 14.
  function automatic logic [3:0] norm_shift(input logic [14:0] m);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < 15; i++) begin
      if (m[i]) k = 4'(14 - i);
    end
    return k;
  endfunction

endpackage

[rtl/ecmp_ifs.sv]
// ----------------------------------------------------------------------------
// ecmp channel interfaces
// Sample, angle and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ecmp_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  modport source(output valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, input ready);
  modport sink(input valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, output ready);
endinterface

interface ecmp_angles_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;
  logic signed [15:0] smoothed_roll;
  logic signed [14:0] smoothed_pitch;
  logic signed [15:0] smoothed_yaw;
  modport source(output valid, roll, pitch, yaw, smoothed_roll, smoothed_pitch,
                 smoothed_yaw, input ready);
  modport sink(input valid, roll, pitch, yaw, smoothed_roll, smoothed_pitch,
               smoothed_yaw, output ready);
endinterface

interface ecmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/ecmp_ctrl.sv]
// ----------------------------------------------------------------------------
// ecmp_ctrl: sequencer of the compass
// Walks the solve steps of one sample and the bit loops of each solve,
// and issues one command per cycle to the datapath.
// ----------------------------------------------------------------------------
module ecmp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output ecmp_pkg::ecmp_cmd_t cmd
);

  ecmp_pkg::ecmp_state_t state, state_next;
  ecmp_pkg::ecmp_step_t  mstep, mstep_next;
  logic [3:0]            bitn, bitn_next;
  logic                  load, push, finish;

  function automatic ecmp_pkg::ecmp_step_t step_after(input ecmp_pkg::ecmp_step_t s);
    ecmp_pkg::ecmp_step_t n;
    unique case (s)
      ecmp_pkg::M_ROLL:  n = ecmp_pkg::M_S1;
      ecmp_pkg::M_S1:    n = ecmp_pkg::M_C1;
      ecmp_pkg::M_C1:    n = ecmp_pkg::M_ROT;
      ecmp_pkg::M_ROT:   n = ecmp_pkg::M_PITCH;
      ecmp_pkg::M_PITCH: n = ecmp_pkg::M_S2;
      ecmp_pkg::M_S2:    n = ecmp_pkg::M_C2;
      ecmp_pkg::M_C2:    n = ecmp_pkg::M_FX;
      ecmp_pkg::M_FX:    n = ecmp_pkg::M_YAW;
      ecmp_pkg::M_YAW:   n = ecmp_pkg::M_LPR;
      ecmp_pkg::M_LPR:   n = ecmp_pkg::M_LPP;
      ecmp_pkg::M_LPP:   n = ecmp_pkg::M_LPY;
      default:           n = ecmp_pkg::M_ROLL;
    endcase
    return n;
  endfunction

  function automatic ecmp_pkg::ecmp_state_t first_state(input ecmp_pkg::ecmp_step_t s);
    ecmp_pkg::ecmp_state_t f;
    unique case (s)
      ecmp_pkg::M_ROLL, ecmp_pkg::M_PITCH, ecmp_pkg::M_YAW: f = ecmp_pkg::S_APREP;
      ecmp_pkg::M_S1, ecmp_pkg::M_C1, ecmp_pkg::M_S2, ecmp_pkg::M_C2: f = ecmp_pkg::S_TPREP;
      ecmp_pkg::M_ROT: f = ecmp_pkg::S_R1;
      ecmp_pkg::M_FX:  f = ecmp_pkg::S_X1;
      default:         f = ecmp_pkg::S_L1;
    endcase
    return f;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ecmp_pkg::S_IDLE;
      mstep     <= ecmp_pkg::M_ROLL;
      bitn      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mstep <= mstep_next;
      bitn  <= bitn_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    mstep_next = mstep;
    bitn_next  = bitn;
    load       = 1'b0;
    push       = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ecmp_pkg::S_IDLE: begin
        if (in_valid) begin
          load       = 1'b1;
          mstep_next = ecmp_pkg::M_ROLL;
          state_next = ecmp_pkg::S_APREP;
        end
      end
      ecmp_pkg::S_APREP: begin
        bitn_next  = ecmp_pkg::TOP_BIT;
        state_next = ecmp_pkg::S_DB1;
      end
      ecmp_pkg::S_DB1: state_next = ecmp_pkg::S_DB2;
      ecmp_pkg::S_DB2: begin
        if (bitn == '0) begin
          state_next = ecmp_pkg::S_P1;
        end else begin
          bitn_next  = bitn - 4'd1;
          state_next = ecmp_pkg::S_DB1;
        end
      end
      ecmp_pkg::S_P1:    state_next = ecmp_pkg::S_P2;
      ecmp_pkg::S_P2:    state_next = ecmp_pkg::S_P3;
      ecmp_pkg::S_P3:    state_next = ecmp_pkg::S_P4;
      ecmp_pkg::S_P4:    state_next = ecmp_pkg::S_P5;
      ecmp_pkg::S_P5:    state_next = ecmp_pkg::S_P6;
      ecmp_pkg::S_P6:    state_next = ecmp_pkg::S_P7;
      ecmp_pkg::S_P7:    state_next = ecmp_pkg::S_AFIN1;
      ecmp_pkg::S_AFIN1: state_next = ecmp_pkg::S_AFIN2;
      ecmp_pkg::S_TPREP: state_next = ecmp_pkg::S_TSQX;
      ecmp_pkg::S_TSQX:  state_next = ecmp_pkg::S_TSQY;
      ecmp_pkg::S_TSQY:  state_next = ecmp_pkg::S_THYP;
      ecmp_pkg::S_THYP: begin
        bitn_next  = ecmp_pkg::TOP_BIT;
        state_next = ecmp_pkg::S_TB1;
      end
      ecmp_pkg::S_TB1: state_next = ecmp_pkg::S_TB2;
      ecmp_pkg::S_TB2: state_next = ecmp_pkg::S_TB3;
      ecmp_pkg::S_TB3: begin
        if (bitn == '0) begin
          state_next = ecmp_pkg::S_TEND;
        end else begin
          bitn_next  = bitn - 4'd1;
          state_next = ecmp_pkg::S_TB1;
        end
      end
      ecmp_pkg::S_R1: state_next = ecmp_pkg::S_R2;
      ecmp_pkg::S_R2: state_next = ecmp_pkg::S_R3;
      ecmp_pkg::S_R3: state_next = ecmp_pkg::S_R4;
      ecmp_pkg::S_R4: state_next = ecmp_pkg::S_R5;
      ecmp_pkg::S_R5: state_next = ecmp_pkg::S_R6;
      ecmp_pkg::S_R6: state_next = ecmp_pkg::S_R7;
      ecmp_pkg::S_X1: state_next = ecmp_pkg::S_X2;
      ecmp_pkg::S_X2: state_next = ecmp_pkg::S_X3;
      ecmp_pkg::S_L1: state_next = ecmp_pkg::S_L2;
      ecmp_pkg::S_L2: state_next = ecmp_pkg::S_L3;
      ecmp_pkg::S_AFIN2, ecmp_pkg::S_TEND, ecmp_pkg::S_R7, ecmp_pkg::S_X3,
      ecmp_pkg::S_L3: finish = 1'b1;
      ecmp_pkg::S_PUSH: begin
        // The result register is free or being emptied in this cycle.
        if (!out_valid || out_ready) begin
          push       = 1'b1;
          state_next = ecmp_pkg::S_IDLE;
        end
      end
      default: state_next = ecmp_pkg::S_IDLE;
    endcase
    if (finish) begin
      if (mstep == ecmp_pkg::M_LPY) begin
        state_next = ecmp_pkg::S_PUSH;
      end else begin
        mstep_next = step_after(mstep);
        state_next = first_state(mstep_next);
      end
    end
  end

  assign in_ready = (state == ecmp_pkg::S_IDLE);

  always_comb begin
    cmd.op   = state;
    cmd.step = mstep;
    cmd.bitn = bitn;
    cmd.load = load;
    cmd.push = push;
  end

endmodule

[rtl/ecmp_dp.sv]
// ----------------------------------------------------------------------------
// ecmp_dp: datapath of the compass
// Holds the sample, the configuration, the solve registers, one shared
// registered multiplier, the filter state and the result register.
// ----------------------------------------------------------------------------
module ecmp_dp (
  input  logic                clk,
  input  logic                rst,
  input  ecmp_pkg::ecmp_cmd_t cmd,
  input  logic signed [15:0]  mag_x,
  input  logic signed [15:0]  mag_y,
  input  logic signed [15:0]  mag_z,
  input  logic signed [15:0]  acc_x,
  input  logic signed [15:0]  acc_y,
  input  logic signed [15:0]  acc_z,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic signed [15:0]  roll,
  output logic signed [14:0]  pitch,
  output logic signed [15:0]  yaw,
  output logic signed [15:0]  smoothed_roll,
  output logic signed [14:0]  smoothed_pitch,
  output logic signed [15:0]  smoothed_yaw
);

  logic signed [15:0] hi_x, hi_y, hi_z;
  logic [14:0]        gain;
  logic signed [15:0] bx, by, bz, gx, gy, gz, fy, fx;
  logic signed [15:0] s_r, c_r;
  logic [14:0]        na, nb, r;
  logic               neg;
  logic [29:0]        xsq;
  logic [30:0]        hyp;
  logic               swap, zden, ynz, x_ge0, x_le0, y_ge0, y_le0;
  logic [19:0]        m1;
  logic [29:0]        tq;
  logic signed [31:0] acc;
  logic [13:0]        a_ang;
  logic signed [15:0] roll_a, pitch_a, yaw_a;
  logic signed [15:0] filt_roll, filt_pitch, filt_yaw;
  logic signed [17:0] lpt;
  logic signed [20:0] ma, mb;
  logic signed [41:0] prod;

  // Operand pair selection and preparation.
  logic signed [15:0] p, q, pc, qc;
  logic [14:0]        pa, qa, ta, tb, tna, tnb, dnum, dden;
  logic [3:0]         tk, dk;
  logic [14:0]        dbit;
  logic signed [32:0] rsum, rdif;

  assign dbit = 15'd1 << cmd.bitn;

  always_comb begin
    unique case (cmd.step)
      ecmp_pkg::M_C1: begin
        p = gz;
        q = gy;
      end
      ecmp_pkg::M_S2: begin
        p = gx;
        q = gz;
      end
      ecmp_pkg::M_C2: begin
        p = gz;
        q = gx;
      end
      ecmp_pkg::M_PITCH: begin
        p = -gx;
        q = gz;
      end
      ecmp_pkg::M_YAW: begin
        p = -fy;
        q = fx;
      end
      default: begin
        p = gy;
        q = gz;
      end
    endcase
    pc = (p == ecmp_pkg::MOST_NEG) ? ecmp_pkg::NEAR_NEG : p;
    qc = (q == ecmp_pkg::MOST_NEG) ? ecmp_pkg::NEAR_NEG : q;
    pa = pc[15] ? 15'(-pc) : pc[14:0];
    qa = qc[15] ? 15'(-qc) : qc[14:0];
    // The sine/cosine solve treats the zero vector as (1,1).
    if (p == '0 && q == '0) begin
      ta = 15'd1;
      tb = 15'd1;
    end else begin
      ta = pa;
      tb = qa;
    end
    tk   = ecmp_pkg::norm_shift(ta | tb);
    tna  = ta << tk;
    tnb  = tb << tk;
    dnum = (pa > qa) ? qa : pa;
    dden = (pa > qa) ? pa : qa;
    dk   = ecmp_pkg::norm_shift(dden);
    rsum = {acc[31], acc} + prod[32:0];
    rdif = {acc[31], acc} - prod[32:0];
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.op)
      ecmp_pkg::S_TSQX: begin
        ma = 21'(na);
        mb = 21'(na);
      end
      ecmp_pkg::S_TSQY: begin
        ma = 21'(nb);
        mb = 21'(nb);
      end
      ecmp_pkg::S_TB1: begin
        ma = 21'(r | dbit);
        mb = 21'(r | dbit);
      end
      ecmp_pkg::S_TB2: begin
        ma = 21'(prod[29:15]);
        mb = 21'(hyp[30:15]);
      end
      ecmp_pkg::S_DB1: begin
        ma = 21'(r | dbit);
        mb = 21'(nb);
      end
      ecmp_pkg::S_P1: begin
        ma = 21'(r[14:5]);
        mb = 21'(r[14:5]);
      end
      ecmp_pkg::S_P2: begin
        ma = 21'(prod[19:0]);
        mb = 21'(r[14:5]);
      end
      ecmp_pkg::S_P3: begin
        ma = 21'(prod[29:15]);
        mb = 21'(ecmp_pkg::ATAN_K2);
      end
      ecmp_pkg::S_P4: begin
        ma = 21'(tq[29:20]);
        mb = 21'(m1);
      end
      ecmp_pkg::S_P5: begin
        ma = 21'(prod[29:15]);
        mb = 21'(ecmp_pkg::ATAN_K3);
      end
      ecmp_pkg::S_P6: begin
        ma = 21'(ecmp_pkg::ATAN_K1);
        mb = 21'(r);
      end
      ecmp_pkg::S_R1: begin
        ma = 21'(by);
        mb = 21'(c_r);
      end
      ecmp_pkg::S_R2: begin
        ma = 21'(bz);
        mb = 21'(s_r);
      end
      ecmp_pkg::S_R3: begin
        ma = 21'(by);
        mb = 21'(s_r);
      end
      ecmp_pkg::S_R4: begin
        ma = 21'(bz);
        mb = 21'(c_r);
      end
      ecmp_pkg::S_R5: begin
        ma = 21'(gy);
        mb = 21'(s_r);
      end
      ecmp_pkg::S_R6: begin
        ma = 21'(gz);
        mb = 21'(c_r);
      end
      ecmp_pkg::S_X1: begin
        ma = 21'(bx);
        mb = 21'(c_r);
      end
      ecmp_pkg::S_X2: begin
        ma = 21'(bz);
        mb = 21'(s_r);
      end
      ecmp_pkg::S_L2: begin
        ma = 21'(gain);
        mb = 21'(lpt);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Angle finishing: polynomial result to first-quadrant angle, then quadrant.
  logic signed [16:0] av, av_sw, av_sub;
  logic signed [15:0] av16, a16, qv, qv_fold;
  logic [13:0]        a_new;

  always_comb begin
    av     = acc[31:15];
    av_sub = 17'(ecmp_pkg::DEG90) - av;
    av16   = av_sub[15:0];
    av_sw  = swap ? 17'(av16) : av;
    if (av_sw < 17'sd0) begin
      a_new = '0;
    end else if (av_sw > 17'(ecmp_pkg::DEG90)) begin
      a_new = 14'(ecmp_pkg::DEG90);
    end else begin
      a_new = av_sw[13:0];
    end
    if (zden) begin
      a_new = ynz ? 14'(ecmp_pkg::DEG90) : 14'd0;
    end
    a16 = {2'b00, a_ang};
    priority if (x_ge0 && y_ge0) begin
      qv = a16;
    end else if (x_le0 && y_ge0) begin
      qv = ecmp_pkg::DEG180 - a16;
    end else if (x_le0 && y_le0) begin
      qv = a16 - ecmp_pkg::DEG180;
    end else begin
      qv = -a16;
    end
    if (qv > ecmp_pkg::DEG90) begin
      qv_fold = ecmp_pkg::DEG180 - qv;
    end else if (qv < -ecmp_pkg::DEG90) begin
      qv_fold = -ecmp_pkg::DEG180 - qv;
    end else begin
      qv_fold = qv;
    end
  end

  // Low-pass update.
  logic signed [15:0] lp_ang, lp_old, f16a, f16b;
  logic signed [17:0] dd0, dd1, dd2;
  logic signed [27:0] v0, v1, v2;

  always_comb begin
    unique case (cmd.step)
      ecmp_pkg::M_LPP: begin
        lp_ang = pitch_a;
        lp_old = filt_pitch;
      end
      ecmp_pkg::M_LPY: begin
        lp_ang = yaw_a;
        lp_old = filt_yaw;
      end
      default: begin
        lp_ang = roll_a;
        lp_old = filt_roll;
      end
    endcase
    dd0 = 18'(lp_ang) - 18'(lp_old);
    dd1 = (dd0 > 18'(ecmp_pkg::DEG180)) ? dd0 - ecmp_pkg::DEG360 : dd0;
    dd2 = (dd1 < -18'(ecmp_pkg::DEG180)) ? dd1 + ecmp_pkg::DEG360 : dd1;
    v0  = 28'(lp_old) + 28'(signed'(prod[41:15]));
    if (cmd.step == ecmp_pkg::M_LPP) begin
      // Pitch folds about plus and minus 90 degrees instead of wrapping.
      f16a = 16'(28'(ecmp_pkg::DEG180) - v0);
      v1   = (v0 > 28'(ecmp_pkg::DEG90)) ? 28'(f16a) : v0;
      f16b = 16'(-28'(ecmp_pkg::DEG180) - v1);
      v2   = (v1 < -28'(ecmp_pkg::DEG90)) ? 28'(f16b) : v1;
    end else begin
      f16a = '0;
      f16b = '0;
      v1   = (v0 > 28'(ecmp_pkg::DEG180)) ? v0 - 28'(ecmp_pkg::DEG360) : v0;
      v2   = (v1 < -28'(ecmp_pkg::DEG180)) ? v1 + 28'(ecmp_pkg::DEG360) : v1;
    end
  end

  // Configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hi_x       <= '0;
      hi_y       <= '0;
      hi_z       <= '0;
      gain       <= ecmp_pkg::GAIN_RESET;
      filt_roll  <= '0;
      filt_pitch <= '0;
      filt_yaw   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (ecmp_pkg::ecmp_reg_t'(cfg_index))
          ecmp_pkg::REG_HARD_IRON_X: hi_x <= cfg_data;
          ecmp_pkg::REG_HARD_IRON_Y: hi_y <= cfg_data;
          ecmp_pkg::REG_HARD_IRON_Z: hi_z <= cfg_data;
          default:                   gain <= cfg_data[14:0];
        endcase
      end
      if (cmd.op == ecmp_pkg::S_L3) begin
        unique case (cmd.step)
          ecmp_pkg::M_LPP: filt_pitch <= v2[15:0];
          ecmp_pkg::M_LPY: filt_yaw   <= v2[15:0];
          default:         filt_roll  <= v2[15:0];
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx <= mag_x - hi_x;
      by <= mag_y - hi_y;
      bz <= mag_z - hi_z;
      gx <= acc_x;
      gy <= acc_y;
      gz <= acc_z;
    end
    unique case (cmd.op)
      ecmp_pkg::S_TPREP: begin
        na  <= tna;
        nb  <= tnb;
        neg <= pc[15];
        r   <= '0;
      end
      ecmp_pkg::S_TSQY: xsq <= prod[29:0];
      ecmp_pkg::S_THYP: hyp <= {1'b0, xsq} + prod[30:0];
      ecmp_pkg::S_TB3: begin
        if (prod[31:0] <= {2'b00, xsq}) r <= r | dbit;
      end
      ecmp_pkg::S_TEND: begin
        unique case (cmd.step)
          ecmp_pkg::M_S1: s_r <= neg ? -16'(r) : 16'(r);
          ecmp_pkg::M_C1: c_r <= neg ? -16'(r) : 16'(r);
          ecmp_pkg::M_S2: s_r <= neg ? 16'(r) : -16'(r);
          default:        c_r <= 16'(r);
        endcase
      end
      ecmp_pkg::S_APREP: begin
        na    <= dnum << dk;
        nb    <= dden << dk;
        r     <= '0;
        swap  <= pa > qa;
        zden  <= (qa == '0);
        ynz   <= (pa != '0);
        x_ge0 <= !qc[15];
        x_le0 <= qc[15] || (qc == '0);
        y_ge0 <= !pc[15];
        y_le0 <= pc[15] || (pc == '0);
      end
      ecmp_pkg::S_DB2: begin
        if (prod[29:15] <= na) r <= r | dbit;
      end
      ecmp_pkg::S_P2:    m1  <= prod[19:0];
      ecmp_pkg::S_P3:    tq  <= prod[29:0];
      ecmp_pkg::S_P4:    acc <= prod[31:0];
      ecmp_pkg::S_P6:    acc <= acc + prod[31:0];
      ecmp_pkg::S_P7:    acc <= acc + prod[31:0];
      ecmp_pkg::S_AFIN1: a_ang <= a_new;
      ecmp_pkg::S_AFIN2: begin
        unique case (cmd.step)
          ecmp_pkg::M_PITCH: pitch_a <= qv_fold;
          ecmp_pkg::M_YAW:   yaw_a   <= qv;
          default:           roll_a  <= qv;
        endcase
      end
      ecmp_pkg::S_R2, ecmp_pkg::S_R4, ecmp_pkg::S_R6, ecmp_pkg::S_X2: acc <= prod[31:0];
      ecmp_pkg::S_R3: fy <= rdif[30:15];
      ecmp_pkg::S_R5: bz <= rsum[30:15];
      ecmp_pkg::S_R7: gz <= rsum[30:15];
      ecmp_pkg::S_X3: fx <= rsum[30:15];
      ecmp_pkg::S_L1: lpt <= dd2;
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      roll           <= roll_a;
      pitch          <= pitch_a[14:0];
      yaw            <= yaw_a;
      smoothed_roll  <= filt_roll;
      smoothed_pitch <= filt_pitch[14:0];
      smoothed_yaw   <= filt_yaw;
    end
  end

endmodule

[rtl/tilt_compensated_ecompass.sv]
// ----------------------------------------------------------------------------
// tilt_compensated_ecompass: integer tilt-compensated electronic compass
// Turns one magnetometer/accelerometer sample into roll, pitch and yaw in
// hundredths of a degree, plus low-pass filtered copies of the three angles.
// ----------------------------------------------------------------------------
// One sample is worked at a time, and the next sample is taken in the cycle
// after the result is moved into the output register. The pace is set by the
// single shared multiplier: three atan2 solves (a 15-bit divide that steps
// through DB1 and DB2 for each bit, plus the polynomial) and four sine/cosine
// solves (TB1, TB2 and TB3 for each bit) make up almost all of the work. A
// finished result waits in its own register, so a new request is accepted
// while it is still unread.
module tilt_compensated_ecompass (
  input logic           clk,
  input logic           rst,
  ecmp_sample_if.sink   sample,
  ecmp_angles_if.source angles,
  ecmp_cfg_if.sink      cfg
);

  ecmp_pkg::ecmp_cmd_t cmd;

  assign cfg.ready = 1'b1;

  ecmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_ready (angles.ready),
    .out_valid (angles.valid),
    .cmd       (cmd)
  );

  ecmp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mag_x          (sample.mag_x),
    .mag_y          (sample.mag_y),
    .mag_z          (sample.mag_z),
    .acc_x          (sample.acc_x),
    .acc_y          (sample.acc_y),
    .acc_z          (sample.acc_z),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .roll           (angles.roll),
    .pitch          (angles.pitch),
    .yaw            (angles.yaw),
    .smoothed_roll  (angles.smoothed_roll),
    .smoothed_pitch (angles.smoothed_pitch),
    .smoothed_yaw   (angles.smoothed_yaw)
  );

endmodule
